### rtl/core/sd_card_spi_mode_responder_unit_assert.svh
// Assertion helpers for the checker file of the SD responder.
`ifndef SD_CARD_SPI_MODE_RESPONDER_UNIT_ASSERT_SVH
`define SD_CARD_SPI_MODE_RESPONDER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SDR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SDR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/sdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdr_pkg;

  // Store geometry.
  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned STORE_BLOCKS = 64;
  localparam int unsigned STORE_SIZE   = BLOCK_BYTES * STORE_BLOCKS;
  localparam int unsigned STORE_AW     = $clog2(STORE_SIZE);
  localparam int unsigned BUF_AW       = $clog2(BLOCK_BYTES);
  localparam int unsigned CNT_W        = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned BLK_W        = (STORE_BLOCKS > 1) ? $clog2(STORE_BLOCKS) : 1;
  localparam int unsigned RP_W         = 32 + $clog2(BLOCK_BYTES) + 1;

  // Read sequencer phases.
  localparam logic [1:0] RD_STATUS = 2'd0;
  localparam logic [1:0] RD_DATA   = 2'd1;
  localparam logic [1:0] RD_CRC0   = 2'd2;
  localparam logic [1:0] RD_CRC1   = 2'd3;

  // Write sequencer phases.
  localparam logic [1:0] WR_TOKEN = 2'd0;
  localparam logic [1:0] WR_DATA  = 2'd1;
  localparam logic [1:0] WR_CRC0  = 2'd2;
  localparam logic [1:0] WR_CRC1  = 2'd3;

  // Command codes.
  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_IF_CHECK     = 6'd8;
  localparam logic [5:0] CMD_CSD_GET      = 6'd9;
  localparam logic [5:0] CMD_CID_GET      = 6'd10;
  localparam logic [5:0] CMD_STOP         = 6'd12;
  localparam logic [5:0] CMD_BLEN_SET     = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
  localparam logic [5:0] CMD_APP_OP_COND  = 6'd41;
  localparam logic [5:0] CMD_APP_NEXT     = 6'd55;
  localparam logic [5:0] CMD_OCR_GET      = 6'd58;

  // Tokens and response codes.
  localparam logic [7:0]  TOKEN_START   = 8'hfe;
  localparam logic [7:0]  R1_IDLE       = 8'h01;
  localparam logic [7:0]  R1_ILLEGAL    = 8'h05;
  localparam logic [7:0]  DATA_ACCEPTED = 8'he5;
  localparam logic [63:0] READ_RESP     = 64'h0000_0000_0000_fe00;
  localparam logic [63:0] WRITE_DONE    = 64'h0100_0000_0000_00e5;
  localparam logic [7:0]  CMD_MASK      = 8'hc0;
  localparam logic [7:0]  CMD_PREFIX    = 8'h40;

  // Identification body of a present card.
  localparam logic [7:0] CID_B0 = 8'h70;
  localparam logic [7:0] CID_B1 = 8'h6c;
  localparam logic [7:0] CID_B2 = 8'h52;

  // CRC16 over one byte, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic [7:0]  d;
    r = c;
    d = b;
    for (int i = 0; i < 8; i++) begin
      r = {r[14:0], 1'b0} ^ ((r[15] ^ d[7]) ? 16'h1021 : 16'h0000);
      d = {d[6:0], 1'b0};
    end
    return r;
  endfunction

  // CRC7 of a 15-byte identification body, shifted into the top bits and
  // terminated with the end bit; evaluated only at elaboration.
  function automatic logic [7:0] crc7_ident(input logic present);
    logic [7:0] c;
    logic [7:0] d;
    c = 8'h00;
    for (int i = 0; i < 15; i++) begin
      d = 8'h00;
      if (present && i == 0) d = CID_B0;
      if (present && i == 1) d = CID_B1;
      if (present && i == 2) d = CID_B2;
      for (int k = 0; k < 8; k++) begin
        c = {c[6:0], 1'b0} ^ ((c[7] ^ d[7]) ? 8'h12 : 8'h00);
        d = {d[6:0], 1'b0};
      end
    end
    return c | 8'h01;
  endfunction

  localparam logic [7:0] CID_CRC   = crc7_ident(1'b1);
  localparam logic [7:0] EMPTY_CRC = crc7_ident(1'b0);

  // Byte of the CID/CSD register; past the CRC byte everything reads zero.
  function automatic logic [7:0] ident_byte(input logic cid_full, input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == CNT_W'(15)) begin
      b = cid_full ? CID_CRC : EMPTY_CRC;
    end else if (cid_full) begin
      if (idx == CNT_W'(0)) b = CID_B0;
      if (idx == CNT_W'(1)) b = CID_B1;
      if (idx == CNT_W'(2)) b = CID_B2;
    end
    return b;
  endfunction

  // Requests from the protocol engine to the store.
  typedef struct packed {
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                buf_we;
    logic [BUF_AW-1:0]   buf_addr;
    logic [7:0]          buf_data;
    logic                commit;
    logic [STORE_AW-1:0] commit_base;
  } store_req_t;

  // Store answers.
  typedef struct packed {
    logic [7:0] rdata;
    logic       busy;
  } store_rsp_t;

endpackage
`default_nettype wire

### rtl/core/sdr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one SPI byte slot or a chip select event per item.
interface sdr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] mosi_byte;

  modport source (output valid, output mode, output mosi_byte, input ready);
  modport sink (input valid, input mode, input mosi_byte, output ready);
endinterface

// Output channel: the byte the card drives for the slot.
interface sdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] miso_byte;
  logic       miso_driven;
  logic       crc_mismatch;

  modport source (output valid, output miso_byte, output miso_driven,
                  output crc_mismatch, input ready);
  modport sink (input valid, input miso_byte, input miso_driven,
                input crc_mismatch, output ready);
endinterface
`default_nettype wire

### rtl/core/sd_card_spi_mode_responder_unit.sv
// An accepted item is held in the slot register, and its result is registered in the output register.
// The slot takes no new item until its current one has moved on to the output register.
// A write's last CRC byte starts a block copy that holds off input until the copy is done.
// Reset: control state goes idle and card_present to 1; a clearing pass then zeroes all
// STORE_SIZE (32768) bytes of the byte store, one byte per cycle, with input held off.
`timescale 1ns / 1ps
`default_nettype none
module sd_card_spi_mode_responder_unit
  import sdr_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  sdr_in_if.sink      in_i,
  sdr_out_if.source   out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       card_present_q;
  store_req_t store_req;
  store_rsp_t store_rsp;

  // Configuration register at byte address 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_present_q <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      card_present_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {31'h0, card_present_q};

  sdr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .card_present_i (card_present_q),
    .in_i           (in_i),
    .out_o          (out_o),
    .store_req_o    (store_req),
    .store_rsp_i    (store_rsp)
  );

  sdr_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

endmodule
`default_nettype wire

### rtl/core/sdr_store.sv
`timescale 1ns / 1ps
`default_nettype none
module sdr_store
  import sdr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);

  logic [7:0] store_mem [STORE_SIZE];
  logic [7:0] buf_mem [BLOCK_BYTES];

  logic                clr_q;
  logic [STORE_AW-1:0] clr_cnt_q;
  logic                cp_act_q;
  logic [CNT_W-1:0]    cp_rd_q;
  logic                cp_wv_q;
  logic [STORE_AW-1:0] cp_wa_q;
  logic [STORE_AW-1:0] cp_base_q;
  logic [7:0]          buf_rdata_q;
  logic [7:0]          rdata_q;
  logic                cp_rd_go;

  assign cp_rd_go = cp_act_q && (cp_rd_q != CNT_W'(BLOCK_BYTES));

  // Clearing pass after reset and the block copy sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      cp_act_q  <= 1'b0;
      cp_rd_q   <= '0;
      cp_wv_q   <= 1'b0;
      cp_wa_q   <= '0;
      cp_base_q <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + STORE_AW'(1);
        if (clr_cnt_q == STORE_AW'(STORE_SIZE - 1)) clr_q <= 1'b0;
      end
      if (req_i.commit) begin
        cp_act_q  <= 1'b1;
        cp_rd_q   <= '0;
        cp_base_q <= req_i.commit_base;
      end else if (cp_act_q && !cp_rd_go) begin
        cp_act_q <= 1'b0;
      end
      if (cp_rd_go) cp_rd_q <= cp_rd_q + CNT_W'(1);
      cp_wv_q <= cp_rd_go;
      cp_wa_q <= cp_base_q + STORE_AW'(cp_rd_q);
    end
  end

  // Block buffer: filled by the write sequencer, drained by the copy.
  always_ff @(posedge clk_i) begin
    if (req_i.buf_we) buf_mem[req_i.buf_addr] <= req_i.buf_data;
    if (cp_rd_go) buf_rdata_q <= buf_mem[cp_rd_q[BUF_AW-1:0]];
  end

  // Byte store: one write port shared by clearing and copy, one read port.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      store_mem[clr_cnt_q] <= 8'h00;
    end else if (cp_wv_q) begin
      store_mem[cp_wa_q] <= buf_rdata_q;
    end
    if (req_i.rd_en) rdata_q <= store_mem[req_i.rd_addr];
  end

  assign rsp_o.rdata = rdata_q;
  assign rsp_o.busy  = clr_q | cp_act_q | cp_wv_q;

endmodule
`default_nettype wire

### rtl/core/sdr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sdr_ctrl
  import sdr_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            card_present_i,
  sdr_in_if.sink         in_i,
  sdr_out_if.source      out_o,
  output store_req_t     store_req_o,
  input  store_rsp_t     store_rsp_i
);

  // Slot register and output register.
  logic       s1_q;
  logic       s1_mode_q;
  logic [7:0] s1_mosi_q;
  logic       ov_q;
  logic [7:0] o_miso_q;
  logic       o_drv_q;
  logic       o_mis_q;

  // Protocol state.
  logic [2:0]       cmd_cnt_q, cmd_cnt_d;
  logic [5:0]       cmd_code_q, cmd_code_d;
  logic [31:0]      cmd_addr_q, cmd_addr_d;
  logic             resp_pend_q, resp_pend_d;
  logic [63:0]      resp_bytes_q, resp_bytes_d;
  logic [3:0]       resp_len_q, resp_len_d;
  logic [3:0]       resp_idx_q, resp_idx_d;
  logic             rd_act_q, rd_act_d;
  logic [1:0]       rd_ph_q, rd_ph_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [15:0]      rd_crc_q, rd_crc_d;
  logic [RP_W-1:0]  rp_q, rp_d;
  logic             wr_act_q, wr_act_d;
  logic [1:0]       wr_ph_q, wr_ph_d;
  logic [CNT_W-1:0] wr_cnt_q, wr_cnt_d;
  logic [15:0]      wr_crc_q, wr_crc_d;
  logic [31:0]      wp_q, wp_d;

  logic       accept;
  logic       ex_go;
  logic [7:0] miso;
  logic       drv;
  logic       mis;
  logic       done;
  logic       buf_we;
  logic       commit;
  logic       ident_sel;
  logic       blk_read;

  assign in_i.ready = !s1_q && !store_rsp_i.busy;
  assign accept     = in_i.valid && in_i.ready;
  assign ex_go      = s1_q && (!ov_q || out_o.ready);

  assign ident_sel = (cmd_code_q == CMD_CID_GET) && card_present_i;
  assign blk_read  = card_present_i && (rp_q < RP_W'(STORE_SIZE));

  // Next state for one slot: drive phase first, then take phase.
  always_comb begin
    cmd_cnt_d    = cmd_cnt_q;
    cmd_code_d   = cmd_code_q;
    cmd_addr_d   = cmd_addr_q;
    resp_pend_d  = resp_pend_q;
    resp_bytes_d = resp_bytes_q;
    resp_len_d   = resp_len_q;
    resp_idx_d   = resp_idx_q;
    rd_act_d     = rd_act_q;
    rd_ph_d      = rd_ph_q;
    rd_cnt_d     = rd_cnt_q;
    rd_crc_d     = rd_crc_q;
    rp_d         = rp_q;
    wr_act_d     = wr_act_q;
    wr_ph_d      = wr_ph_q;
    wr_cnt_d     = wr_cnt_q;
    wr_crc_d     = wr_crc_q;
    wp_d         = wp_q;
    miso         = 8'hff;
    drv          = 1'b0;
    mis          = 1'b0;
    done         = 1'b0;
    buf_we       = 1'b0;
    commit       = 1'b0;

    if (s1_mode_q) begin
      // Chip select changed: drop command, response and read.
      cmd_cnt_d   = '0;
      resp_pend_d = 1'b0;
      rd_act_d    = 1'b0;
    end else begin
      // Queued response bytes go out first.
      if (resp_pend_q) begin
        if (resp_idx_q < resp_len_q && resp_idx_q < 4'd8) begin
          miso       = resp_bytes_q[{resp_idx_q[2:0], 3'b000} +: 8];
          resp_idx_d = resp_idx_q + 4'd1;
          drv        = 1'b1;
          done       = 1'b1;
        end else begin
          if (rd_act_q) begin
            rd_ph_d  = RD_DATA;
            rd_crc_d = 16'h0000;
          end
          resp_pend_d = 1'b0;
        end
      end

      // Read data sequencer.
      if (!done && rd_act_q) begin
        drv = 1'b1;
        unique case (rd_ph_d)
          RD_DATA: begin
            if (cmd_code_q == CMD_CSD_GET || cmd_code_q == CMD_CID_GET) begin
              miso     = ident_byte(ident_sel, rd_cnt_q);
              rd_crc_d = crc16_byte(rd_crc_d, miso);
              rd_cnt_d = rd_cnt_q + CNT_W'(1);
              if (rd_cnt_d >= CNT_W'(16)) rd_ph_d = RD_CRC0;
            end else if (cmd_code_q == CMD_READ_SINGLE || cmd_code_q == CMD_READ_MULTI) begin
              miso     = blk_read ? store_rsp_i.rdata : 8'hff;
              rp_d     = rp_q + RP_W'(1);
              rd_crc_d = crc16_byte(rd_crc_d, miso);
              rd_cnt_d = rd_cnt_q + CNT_W'(1);
              if (rd_cnt_d >= CNT_W'(BLOCK_BYTES)) rd_ph_d = RD_CRC0;
            end
          end
          RD_CRC0: begin
            miso    = rd_crc_q[15:8];
            rd_ph_d = RD_CRC1;
          end
          RD_CRC1: begin
            miso     = rd_crc_q[7:0];
            rd_cnt_d = '0;
            rd_crc_d = 16'h0000;
            rd_ph_d  = RD_DATA;
          end
          default: begin
            miso     = 8'hff;
            rd_act_d = 1'b0;
          end
        endcase
      end

      // Take phase: write sequencer or command parser.
      if (wr_act_q) begin
        unique case (wr_ph_q)
          WR_TOKEN: begin
            if (s1_mosi_q == TOKEN_START) begin
              wr_ph_d  = WR_DATA;
              wr_crc_d = 16'h0000;
            end
          end
          WR_DATA: begin
            buf_we   = 1'b1;
            wr_crc_d = crc16_byte(wr_crc_q, s1_mosi_q);
            wr_cnt_d = wr_cnt_q + CNT_W'(1);
            if (wr_cnt_d >= CNT_W'(BLOCK_BYTES)) wr_ph_d = WR_CRC0;
          end
          WR_CRC0: begin
            mis     = (s1_mosi_q != wr_crc_q[15:8]);
            wr_ph_d = WR_CRC1;
          end
          default: begin
            mis          = (s1_mosi_q != wr_crc_q[7:0]);
            wr_ph_d      = WR_TOKEN;
            resp_pend_d  = 1'b1;
            resp_idx_d   = 4'd0;
            resp_len_d   = 4'd8;
            resp_bytes_d = WRITE_DONE;
            wr_act_d     = 1'b0;
            commit       = card_present_i && (wp_q < 32'(STORE_BLOCKS));
          end
        endcase
      end else if (cmd_cnt_q == 3'd0) begin
        if ((s1_mosi_q & CMD_MASK) == CMD_PREFIX) begin
          cmd_code_d = s1_mosi_q[5:0];
          cmd_cnt_d  = 3'd1;
        end
      end else if (cmd_cnt_q >= 3'd5) begin
        cmd_cnt_d = 3'd0;
        unique case (cmd_code_q)
          CMD_GO_IDLE: begin
            resp_pend_d = 1'b1; resp_idx_d = 4'd0; resp_len_d = 4'd1;
            resp_bytes_d = 64'(R1_IDLE);
          end
          CMD_IF_CHECK, CMD_OCR_GET: begin
            resp_pend_d = 1'b1; resp_idx_d = 4'd0; resp_len_d = 4'd5;
            resp_bytes_d = 64'h0;
          end
          CMD_CSD_GET, CMD_CID_GET, CMD_READ_SINGLE, CMD_READ_MULTI: begin
            if (cmd_code_q == CMD_READ_SINGLE || cmd_code_q == CMD_READ_MULTI) begin
              rp_d = RP_W'(cmd_addr_q) * RP_W'(BLOCK_BYTES);
            end
            resp_pend_d = 1'b1; resp_idx_d = 4'd0; resp_len_d = 4'd2;
            resp_bytes_d = READ_RESP;
            rd_act_d = 1'b1; rd_ph_d = RD_STATUS; rd_cnt_d = '0;
          end
          CMD_STOP: begin
          end
          CMD_BLEN_SET, CMD_APP_OP_COND, CMD_APP_NEXT: begin
            resp_pend_d = 1'b1; resp_idx_d = 4'd0; resp_len_d = 4'd1;
            resp_bytes_d = 64'h0;
          end
          CMD_WRITE_SINGLE, CMD_WRITE_MULTI: begin
            wp_d = cmd_addr_q;
            resp_pend_d = 1'b1; resp_idx_d = 4'd0; resp_len_d = 4'd1;
            resp_bytes_d = 64'(TOKEN_START);
            wr_act_d = 1'b1; wr_ph_d = WR_TOKEN; wr_cnt_d = '0;
          end
          default: begin
            resp_pend_d = 1'b1; resp_idx_d = 4'd0; resp_len_d = 4'd1;
            resp_bytes_d = 64'(R1_ILLEGAL);
          end
        endcase
      end else begin
        cmd_addr_d = {cmd_addr_q[23:0], s1_mosi_q};
        cmd_cnt_d  = cmd_cnt_q + 3'd1;
      end
    end
  end

  // Store requests.
  assign store_req_o.rd_en       = accept;
  assign store_req_o.rd_addr     = rp_q[STORE_AW-1:0];
  assign store_req_o.buf_we      = ex_go && buf_we;
  assign store_req_o.buf_addr    = wr_cnt_q[BUF_AW-1:0];
  assign store_req_o.buf_data    = s1_mosi_q;
  assign store_req_o.commit      = ex_go && commit;
  assign store_req_o.commit_base = STORE_AW'(wp_q[BLK_W-1:0]) * STORE_AW'(BLOCK_BYTES);

  // Slot and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (accept) s1_q <= 1'b1;
      else if (ex_go) s1_q <= 1'b0;
      if (ex_go) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= in_i.mode;
      s1_mosi_q <= in_i.mosi_byte;
    end
    if (ex_go) begin
      o_miso_q <= miso;
      o_drv_q  <= drv;
      o_mis_q  <= mis;
    end
  end

  // Protocol state update once per slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_cnt_q    <= '0;
      cmd_code_q   <= '0;
      cmd_addr_q   <= '0;
      resp_pend_q  <= 1'b0;
      resp_bytes_q <= '0;
      resp_len_q   <= '0;
      resp_idx_q   <= '0;
      rd_act_q     <= 1'b0;
      rd_ph_q      <= RD_STATUS;
      rd_cnt_q     <= '0;
      rd_crc_q     <= '0;
      rp_q         <= '0;
      wr_act_q     <= 1'b0;
      wr_ph_q      <= WR_TOKEN;
      wr_cnt_q     <= '0;
      wr_crc_q     <= '0;
      wp_q         <= '0;
    end else if (ex_go) begin
      cmd_cnt_q    <= cmd_cnt_d;
      cmd_code_q   <= cmd_code_d;
      cmd_addr_q   <= cmd_addr_d;
      resp_pend_q  <= resp_pend_d;
      resp_bytes_q <= resp_bytes_d;
      resp_len_q   <= resp_len_d;
      resp_idx_q   <= resp_idx_d;
      rd_act_q     <= rd_act_d;
      rd_ph_q      <= rd_ph_d;
      rd_cnt_q     <= rd_cnt_d;
      rd_crc_q     <= rd_crc_d;
      rp_q         <= rp_d;
      wr_act_q     <= wr_act_d;
      wr_ph_q      <= wr_ph_d;
      wr_cnt_q     <= wr_cnt_d;
      wr_crc_q     <= wr_crc_d;
      wp_q         <= wp_d;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.miso_byte    = o_miso_q;
  assign out_o.miso_driven  = o_drv_q;
  assign out_o.crc_mismatch = o_mis_q;

endmodule
`default_nettype wire

### rtl/core/sdr_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sd_card_spi_mode_responder_unit_assert.svh"
module sdr_chk (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [7:0] miso_byte_i,
  input wire       miso_driven_i,
  input wire       crc_mismatch_i
);

  // A stalled result keeps its payload.
  `SDR_ASSERT(a_out_hold,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(miso_byte_i) &&
      $stable(miso_driven_i) && $stable(crc_mismatch_i),
    "result changed while stalled")

  // An undriven slot always shows an idle bus.
  `SDR_ASSERT(a_idle_ff,
    out_valid_i && !miso_driven_i |-> miso_byte_i == 8'hff,
    "undriven slot is not 0xff")

  // A slot holds off input in the cycle after its item is accepted.
  `SDR_ASSERT(a_slot_gap,
    in_valid_i && in_ready_i |=> !in_ready_i,
    "item accepted in back-to-back cycles")

  // The store clearing pass keeps input off right after reset.
  `SDR_ASSERT_RST(a_reset_clear,
    !rst_ni |=> !in_ready_i,
    "input ready during store clear")

endmodule

bind sd_card_spi_mode_responder_unit sdr_chk u_sdr_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .miso_byte_i    (out_o.miso_byte),
  .miso_driven_i  (out_o.miso_driven),
  .crc_mismatch_i (out_o.crc_mismatch)
);
`default_nettype wire

### test/sd_card_spi_mode_responder_unit_test.sv
`timescale 1ns / 1ps
module sd_card_spi_mode_responder_unit_test;
  import sdr_pkg::*;

  localparam int unsigned STORE_BYTES = BLOCK_BYTES * STORE_BLOCKS;

  // One expected slot result.
  typedef struct {
    logic [7:0] miso;
    logic       driven;
    logic       mismatch;
  } slot_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sdr_in_if  in_if ();
  sdr_out_if out_if ();

  sd_card_spi_mode_responder_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Card model state.
  logic        card_on;
  logic [2:0]  cmd_bytes;
  logic [5:0]  cmd_code;
  logic [31:0] cmd_addr;
  logic        resp_busy;
  logic [63:0] resp_data;
  logic [3:0]  resp_len;
  logic [3:0]  resp_idx;
  logic        rd_on;
  logic [1:0]  rd_phase;
  logic [9:0]  rd_cnt;
  logic [15:0] rd_crc;
  logic [63:0] rd_ptr;
  logic        wr_on;
  logic [1:0]  wr_phase;
  logic [9:0]  wr_cnt;
  logic [15:0] wr_crc;
  logic [63:0] wr_ptr;
  logic [7:0]  card_mem [STORE_BYTES];
  logic [7:0]  wr_buf [BLOCK_BYTES];

  slot_result_t miso_q[$];
  slot_result_t got_exp;
  int          errors;
  int          sent_count;
  int          burst_left;
  int          hold_token;
  int          hold_seen;
  int          hold_left;
  int          rx_cycle;
  int          rx_pattern;
  logic        rx_take;
  logic [7:0]  rx_miso;
  logic        rx_drv;
  logic        rx_mis;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // CRC16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic [7:0]  d;
    r = c;
    d = b;
    for (int i = 0; i < 8; i++) begin
      r = (r << 1) ^ ((r[15] ^ d[7]) ? 16'h1021 : 16'h0000);
      d = d << 1;
    end
    return r;
  endfunction

  // CID or CSD byte at the given index.
  function automatic logic [7:0] ident_value(input logic cid, input logic [9:0] idx);
    logic [7:0] body [15];
    logic [7:0] c;
    logic [7:0] d;
    for (int i = 0; i < 15; i++) body[i] = 8'h00;
    if (cid && card_on) begin
      body[0] = 8'h70;
      body[1] = 8'h6c;
      body[2] = 8'h52;
    end
    if (idx < 15) return body[idx];
    if (idx > 15) return 8'h00;
    c = 8'h00;
    for (int i = 0; i < 15; i++) begin
      d = body[i];
      for (int k = 0; k < 8; k++) begin
        c = (c << 1) ^ ((c[7] ^ d[7]) ? 8'h12 : 8'h00);
        d = d << 1;
      end
    end
    return c | 8'h01;
  endfunction

  function automatic void queue_reply(input logic [3:0] len, input logic [63:0] bytes);
    resp_busy = 1'b1;
    resp_idx  = 4'd0;
    resp_len  = len;
    resp_data = bytes;
  endfunction

  function automatic void start_read();
    queue_reply(4'd2, READ_RESP);
    rd_on    = 1'b1;
    rd_phase = RD_STATUS;
    rd_cnt   = '0;
  endfunction

  // Decode of a complete command.
  function automatic void execute_command();
    case (cmd_code)
      CMD_GO_IDLE: queue_reply(4'd1, 64'(R1_IDLE));
      CMD_IF_CHECK, CMD_OCR_GET: queue_reply(4'd5, 64'd0);
      CMD_CSD_GET, CMD_CID_GET: start_read();
      CMD_STOP: ;
      CMD_BLEN_SET, CMD_APP_OP_COND, CMD_APP_NEXT: queue_reply(4'd1, 64'd0);
      CMD_READ_SINGLE, CMD_READ_MULTI: begin
        rd_ptr = 64'(cmd_addr) * BLOCK_BYTES;
        start_read();
      end
      CMD_WRITE_SINGLE, CMD_WRITE_MULTI: begin
        wr_ptr = 64'(cmd_addr) * BLOCK_BYTES;
        queue_reply(4'd1, 64'(TOKEN_START));
        wr_on    = 1'b1;
        wr_phase = WR_TOKEN;
        wr_cnt   = '0;
      end
      default: queue_reply(4'd1, 64'(R1_ILLEGAL));
    endcase
  endfunction

  // Computes the MISO slot for one item and advances the card state.
  function automatic slot_result_t predict_slot(input logic m, input logic [7:0] mosi);
    slot_result_t r;
    logic         done;
    r.miso = 8'hff;
    r.driven = 1'b0;
    r.mismatch = 1'b0;
    done = 1'b0;
    if (m) begin
      cmd_bytes = '0;
      resp_busy = 1'b0;
      rd_on = 1'b0;
      return r;
    end
    // Drive side of the slot.
    if (resp_busy) begin
      if (resp_idx < resp_len && resp_idx < 8) begin
        r.miso = resp_data[8*resp_idx +: 8];
        resp_idx++;
        r.driven = 1'b1;
        done = 1'b1;
      end else begin
        if (rd_on) begin
          rd_phase = RD_DATA;
          rd_crc = '0;
        end
        resp_busy = 1'b0;
      end
    end
    if (!done && rd_on) begin
      r.driven = 1'b1;
      case (rd_phase)
        RD_DATA: begin
          if (cmd_code == CMD_CSD_GET || cmd_code == CMD_CID_GET) begin
            r.miso = ident_value(cmd_code == CMD_CID_GET, rd_cnt);
            rd_crc = crc16_step(rd_crc, r.miso);
            rd_cnt++;
            if (rd_cnt >= 16) rd_phase = RD_CRC0;
          end else if (cmd_code == CMD_READ_SINGLE || cmd_code == CMD_READ_MULTI) begin
            r.miso = 8'hff;
            if (card_on && rd_ptr < STORE_BYTES) r.miso = card_mem[rd_ptr];
            rd_ptr++;
            rd_crc = crc16_step(rd_crc, r.miso);
            rd_cnt++;
            if (rd_cnt >= BLOCK_BYTES) rd_phase = RD_CRC0;
          end
        end
        RD_CRC0: begin
          r.miso = rd_crc[15:8];
          rd_phase = RD_CRC1;
        end
        RD_CRC1: begin
          r.miso = rd_crc[7:0];
          rd_cnt = '0;
          rd_crc = '0;
          rd_phase = RD_DATA;
        end
        default: begin
          r.miso = 8'hff;
          rd_on = 1'b0;
        end
      endcase
    end
    // Take side of the slot.
    if (wr_on) begin
      case (wr_phase)
        WR_TOKEN: begin
          if (mosi == TOKEN_START) begin
            wr_phase = WR_DATA;
            wr_crc = '0;
          end
        end
        WR_DATA: begin
          wr_buf[wr_cnt] = mosi;
          wr_crc = crc16_step(wr_crc, mosi);
          wr_cnt++;
          if (wr_cnt >= BLOCK_BYTES) wr_phase = WR_CRC0;
        end
        WR_CRC0: begin
          r.mismatch = (mosi != wr_crc[15:8]);
          wr_phase = WR_CRC1;
        end
        default: begin
          r.mismatch = (mosi != wr_crc[7:0]);
          wr_phase = WR_TOKEN;
          queue_reply(4'd8, WRITE_DONE);
          wr_on = 1'b0;
          if (card_on) begin
            for (int i = 0; i < BLOCK_BYTES; i++) begin
              if (wr_ptr + i < STORE_BYTES) card_mem[wr_ptr + i] = wr_buf[i];
            end
          end
        end
      endcase
    end else if (cmd_bytes == 0) begin
      if ((mosi & CMD_MASK) == CMD_PREFIX) begin
        cmd_code = mosi[5:0];
        cmd_bytes = 3'd1;
      end
    end else if (cmd_bytes >= 5) begin
      execute_command();
      cmd_bytes = '0;
    end else begin
      cmd_addr = {cmd_addr[23:0], mosi};
      cmd_bytes++;
    end
    return r;
  endfunction

  // Offers one item and waits for it to be taken; bursts end in random gaps.
  // Ready is sampled mid-cycle so that the value seen is the one at the next edge.
  task automatic send_item(input logic m, input logic [7:0] b);
    int   gap;
    logic rdy;
    in_if.valid     <= 1'b1;
    in_if.mode      <= m;
    in_if.mosi_byte <= b;
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    miso_q.push_back(predict_slot(m, b));
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic sender_idle();
    if (in_if.valid) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every result has come, then lets a block copy finish.
  task automatic wait_all_results();
    sender_idle();
    while (miso_q.size() != 0) @(posedge clk_i);
    repeat (BLOCK_BYTES + 64) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'd0) card_on = data[0];
    @(posedge clk_i);
  endtask

  task automatic send_command(input logic [5:0] code, input logic [31:0] addr);
    send_item(1'b0, CMD_PREFIX | 8'(code));
    for (int i = 3; i >= 0; i--) send_item(1'b0, addr[8*i +: 8]);
    send_item(1'b0, 8'($urandom));
  endtask

  task automatic send_fill(input int n);
    for (int i = 0; i < n; i++) send_item(1'b0, 8'hff);
  endtask

  function automatic logic [31:0] pick_block();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return $urandom_range(0, 3);
      4: return STORE_BLOCKS - 1;
      5: return STORE_BLOCKS;
      6: return $urandom;
      default: return $urandom_range(0, STORE_BLOCKS - 1);
    endcase
  endfunction

  // Whole block write with a correct or damaged CRC.
  task automatic send_block_write(input logic [31:0] blk);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = '0;
    send_command($urandom_range(0, 1) ? CMD_WRITE_SINGLE : CMD_WRITE_MULTI, blk);
    send_fill($urandom_range(0, 3));
    send_item(1'b0, TOKEN_START);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      b = 8'($urandom);
      crc = crc16_step(crc, b);
      send_item(1'b0, b);
    end
    if ($urandom_range(0, 3) == 0) crc ^= 16'(1 << $urandom_range(0, 15));
    send_item(1'b0, crc[15:8]);
    send_item(1'b0, crc[7:0]);
    send_fill(10);
  endtask

  // Read of CID, CSD or store data, ended by a chip select event.
  task automatic send_read(input logic [5:0] code, input int n);
    send_command(code, pick_block());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) send_item(1'b0, 8'($urandom));
      else send_item(1'b0, 8'hff);
    end
    send_item(1'b1, 8'($urandom));
  endtask

  // Handshake and payload as they stand just before the next rising edge.
  always @(negedge clk_i) begin
    rx_take = rst_ni && out_if.valid && out_if.ready;
    rx_miso = out_if.miso_byte;
    rx_drv  = out_if.miso_driven;
    rx_mis  = out_if.crc_mismatch;
  end

  // Receiver: checks each result and stalls on a changing pattern.
  always @(posedge clk_i) begin
    if (rx_take) begin
      if (miso_q.size() == 0) begin
        $error("result with no expectation: miso_byte %h", rx_miso);
        errors++;
      end else begin
        got_exp = miso_q.pop_front();
        if (rx_miso !== got_exp.miso) begin
          $error("miso_byte expected %h actual %h", got_exp.miso, rx_miso);
          errors++;
        end
        if (rx_drv !== got_exp.driven) begin
          $error("miso_driven expected %b actual %b", got_exp.driven, rx_drv);
          errors++;
        end
        if (rx_mis !== got_exp.mismatch) begin
          $error("crc_mismatch expected %b actual %b", got_exp.mismatch, rx_mis);
          errors++;
        end
      end
    end
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_pattern = $urandom_range(0, 3);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_pattern)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= $urandom_range(0, 1);
        2: out_if.ready <= (rx_cycle % 4 == 0);
        default: out_if.ready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  // Short directed check of GO_IDLE, an illegal command, STOP and chip select.
  task automatic test_commands();
    send_command(CMD_GO_IDLE, 32'h0000_0000);
    send_fill(2);
    send_command(6'd63, 32'hffff_ffff);
    send_fill(1);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hbf);
    send_command(CMD_STOP, 32'h1234_5678);
    send_fill(1);
  endtask

  // Mostly well-formed transactions with random content, some noise.
  task automatic test_random_traffic(input int items);
    int start;
    int n;
    start = sent_count;
    hold_token++;
    while (sent_count - start < items) begin
      case ($urandom_range(0, 15))
        0: send_item(1'b1, 8'($urandom));
        1: send_item(1'b0, 8'($urandom));
        2, 3: begin
          case ($urandom_range(0, 7))
            0: send_command(CMD_GO_IDLE, $urandom);
            1: send_command(CMD_IF_CHECK, $urandom);
            2: send_command(CMD_OCR_GET, $urandom);
            3: send_command(CMD_STOP, $urandom);
            4: send_command(CMD_BLEN_SET, $urandom);
            5: send_command(CMD_APP_OP_COND, $urandom);
            6: send_command(CMD_APP_NEXT, $urandom);
            default: send_command(6'($urandom), $urandom);
          endcase
          send_fill($urandom_range(0, 9));
        end
        4, 5: send_read($urandom_range(0, 1) ? CMD_CID_GET : CMD_CSD_GET,
                        $urandom_range(2, 24));
        6, 7, 8, 9, 10: begin
          n = ($urandom_range(0, 5) == 0) ? $urandom_range(516, 1100) : $urandom_range(3, 40);
          send_read($urandom_range(0, 1) ? CMD_READ_SINGLE : CMD_READ_MULTI, n);
        end
        11, 12: send_block_write(pick_block());
        default: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_card_absent();
    wait_all_results();
    apb_write(3'd0, 32'd0);
    send_read(CMD_CID_GET, 20);
    test_random_traffic(250);
    wait_all_results();
    apb_write(3'd0, 32'd1);
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.mode      = 1'b0;
    in_if.mosi_byte = 8'h00;
    out_if.ready    = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    errors = 0;
    sent_count = 0;
    burst_left = 1;
    hold_token = 0;
    hold_seen = 0;
    hold_left = 0;
    rx_cycle = 0;
    rx_pattern = 0;
    card_on = 1'b1;
    cmd_bytes = '0;
    cmd_code = '0;
    cmd_addr = '0;
    resp_busy = 1'b0;
    resp_data = '0;
    resp_len = '0;
    resp_idx = '0;
    rd_on = 1'b0;
    rd_phase = RD_STATUS;
    rd_cnt = '0;
    rd_crc = '0;
    rd_ptr = '0;
    wr_on = 1'b0;
    wr_phase = WR_TOKEN;
    wr_cnt = '0;
    wr_crc = '0;
    wr_ptr = '0;
    for (int i = 0; i < STORE_BYTES; i++) card_mem[i] = 8'h00;
    for (int i = 0; i < BLOCK_BYTES; i++) wr_buf[i] = 8'h00;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_write(3'd0, 32'd1);
    test_commands();
    test_random_traffic(450);
    wait_all_results();
    test_card_absent();
    test_random_traffic(450);

    wait_all_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/sdr_pkg.sv
rtl/core/sdr_if.sv
rtl/core/sdr_store.sv
rtl/core/sdr_ctrl.sv
rtl/core/sd_card_spi_mode_responder_unit.sv
rtl/core/sdr_chk.sv
test/sd_card_spi_mode_responder_unit_test.sv
